### src/infix_to_postfix_converter_defines.svh
// Assertion helpers shared by the converter RTL.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/itp_pkg.sv
package itp_pkg;

    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_CARET  = 8'h5E;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_NUL    = 8'h00;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    typedef enum logic [2:0] {
        K_ALNUM,
        K_LPAREN,
        K_RPAREN,
        K_OP,
        K_END
    } t_kind;

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        case (c)
            C_PLUS, C_MINUS: p = 2'd1;
            C_STAR, C_SLASH: p = 2'd2;
            C_CARET:         p = 2'd3;
            default:         p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic t_kind classify(input logic [7:0] c, input logic is_end);
        t_kind k;
        if (is_end) begin
            k = K_END;
        end else if (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
            k = K_ALNUM;
        end else if (c == C_LPAREN) begin
            k = K_LPAREN;
        end else if (c == C_RPAREN) begin
            k = K_RPAREN;
        end else begin
            k = K_OP;
        end
        return k;
    endfunction

endpackage

### src/itp_ram.sv
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/infix_to_postfix_converter.sv
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+------------------------------------------
// input   | in        | i_valid / o_stall  | i_in_char, i_is_end
// output  | out       | o_valid / i_stall  | o_out_char, o_run_last, o_expr_done,
//         |           |                    | o_overflowed
//
// One item at a time: the item is accepted, each stacked operator is popped in turn,
// and a closing step pushes, discards or emits. An end item pops every entry; the last
// pop and the end marker leave in steps of their own.
// The pop rate is set by the single read port of the stack RAM and its registered read.
// Reset is synchronous, active low, and clears the stack count and overflow flag.
// A stall on the output side only delays the next emit; the held result is never lost.
`include "infix_to_postfix_converter_defines.svh"

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_is_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_run_last,
    output logic       o_expr_done,
    output logic       o_overflowed
);

    import itp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Control state
    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic          r_pend, n_pend;
    logic          r_hold_v, n_hold_v;
    logic          r_ovalid, n_ovalid;

    // Payload
    t_kind         r_kind, n_kind;
    logic [7:0]    r_char, n_char;
    logic [7:0]    r_top, n_top;
    logic [7:0]    r_hold, n_hold;
    logic [7:0]    r_ochar, n_ochar;
    logic          r_olast, n_olast;
    logic          r_odone, n_odone;
    logic          r_oovf, n_oovf;

    // Stack RAM port signals
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    logic [7:0]    top_cur;
    logic [CW-1:0] cnt_m2;
    logic          cnt_nz;
    logic          out_free;
    logic          pop_cond;
    logic          fin;

    itp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_char),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // The top of stack lives in r_top; after a pop the new top arrives from the RAM
    // in the next cycle and is forwarded from the read port until it is captured.
    // Reads happen only on pops and writes only on pushes, so they never overlap.
    assign top_cur  = r_pend ? rd_data : r_top;
    assign cnt_m2   = r_cnt - CW'(2);
    assign cnt_nz   = (r_cnt != '0);
    assign out_free = !r_ovalid || !i_stall;

    // Pop while the top binds at least as tight as the item; ')' stops at '('.
    always_comb begin
        case (r_kind)
            K_END:    pop_cond = cnt_nz;
            K_RPAREN: pop_cond = cnt_nz && (top_cur != C_LPAREN);
            K_OP:     pop_cond = cnt_nz && (prec_of(top_cur) >= prec_of(r_char));
            default:  pop_cond = 1'b0;
        endcase
    end

    // The closing step of an item: the held pop leaves with run_last set, unless an
    // end marker still follows it.
    always_comb begin
        if (pop_cond) begin
            fin = 1'b0;
        end else begin
            case (r_kind)
                K_END:   fin = !r_hold_v && out_free;
                K_ALNUM: fin = out_free;
                default: fin = !r_hold_v || out_free;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (fin) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and output controls
    always_comb begin
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_pend   = 1'b0;
        n_hold_v = r_hold_v;
        n_ovalid = r_ovalid && i_stall;
        n_kind   = r_kind;
        n_char   = r_char;
        n_top    = r_pend ? rd_data : r_top;
        n_hold   = r_hold;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        n_odone  = r_odone;
        n_oovf   = r_oovf;
        rd_en    = 1'b0;
        rd_addr  = cnt_m2[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_cnt[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_char   = i_in_char;
                    n_kind   = classify(i_in_char, i_is_end);
                    n_hold_v = 1'b0;
                end
            end
            S_RUN: begin
                if (pop_cond) begin
                    // Pop into the hold stage; release the previous pop downstream.
                    if (!r_hold_v || out_free) begin
                        if (r_hold_v) begin
                            n_ovalid = 1'b1;
                            n_ochar  = r_hold;
                            n_olast  = 1'b0;
                            n_odone  = 1'b0;
                            n_oovf   = r_ovf;
                        end
                        n_hold   = top_cur;
                        n_hold_v = 1'b1;
                        n_cnt    = r_cnt - CW'(1);
                        if (r_cnt > CW'(1)) begin
                            rd_en  = 1'b1;
                            n_pend = 1'b1;
                        end
                    end
                end else if (r_kind == K_END) begin
                    if (r_hold_v) begin
                        if (out_free) begin
                            n_ovalid = 1'b1;
                            n_ochar  = r_hold;
                            n_olast  = 1'b0;
                            n_odone  = 1'b0;
                            n_oovf   = r_ovf;
                            n_hold_v = 1'b0;
                        end
                    end else if (out_free) begin
                        // Close the expression and start the next one clean.
                        n_ovalid = 1'b1;
                        n_ochar  = C_NUL;
                        n_olast  = 1'b1;
                        n_odone  = 1'b1;
                        n_oovf   = r_ovf;
                        n_cnt    = '0;
                        n_ovf    = 1'b0;
                    end
                end else if (r_kind == K_ALNUM) begin
                    if (out_free) begin
                        n_ovalid = 1'b1;
                        n_ochar  = r_char;
                        n_olast  = 1'b1;
                        n_odone  = 1'b0;
                        n_oovf   = r_ovf;
                    end
                end else if (fin) begin
                    if (r_hold_v) begin
                        n_ovalid = 1'b1;
                        n_ochar  = r_hold;
                        n_olast  = 1'b1;
                        n_odone  = 1'b0;
                        n_oovf   = r_ovf;
                        n_hold_v = 1'b0;
                    end
                    if (r_kind == K_RPAREN) begin
                        // Drop the matching '(' if one is on top.
                        if (cnt_nz) begin
                            n_cnt = r_cnt - CW'(1);
                            if (r_cnt > CW'(1)) begin
                                rd_en  = 1'b1;
                                n_pend = 1'b1;
                            end
                        end
                    end else if (r_cnt == CW'(STACK_DEPTH)) begin
                        n_ovf = 1'b1;
                    end else begin
                        wr_en = 1'b1;
                        n_top = r_char;
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_pend   <= 1'b0;
            r_hold_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_pend   <= n_pend;
            r_hold_v <= n_hold_v;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_char  <= n_char;
        r_top   <= n_top;
        r_hold  <= n_hold;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
        r_odone <= n_odone;
        r_oovf  <= n_oovf;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_out_char   = r_ochar;
    assign o_run_last   = r_olast;
    assign o_expr_done  = r_odone;
    assign o_overflowed = r_oovf;

    `ITP_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(STACK_DEPTH),
        "stack count beyond depth")
    `ITP_ASSERT_NOW(a_hold_in_run, i_clk, i_rst_n, r_hold_v, r_state == S_RUN,
        "held pop outside an item")
    `ITP_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n,
        (r_state == S_RUN) && fin && (r_kind == K_END),
        (r_cnt == '0) && !r_ovf && o_valid && o_expr_done,
        "end item did not close the expression")

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import itp_pkg::*;

    localparam int DEPTH      = 32;
    localparam int HALF_CYCLE = 1;
    localparam int IDLE_LIMIT = 1000;  // cycles with no handshake on either side
    localparam int TAIL_WAIT  = 64;    // covers a full drain of the stack and then some
    localparam int N_RANDOM   = 400;

    localparam logic [7:0] CH_DIG0 = "0";
    localparam logic [7:0] CH_UPA  = "A";
    localparam logic [7:0] CH_LOWA = "a";
    localparam logic [7:0] OPS [5] = '{C_PLUS, C_MINUS, C_STAR, C_SLASH, C_CARET};

    // One input item: a character, or an end-of-expression marker.
    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } char_item_t;

    // One postfix result as it leaves the converter.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       done;
        logic       ovf;
    } postfix_res_t;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_in_char = '0;
    logic       i_is_end  = 1'b0;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_char;
    logic       o_run_last;
    logic       o_expr_done;
    logic       o_overflowed;

    char_item_t   char_feed [$];    // items waiting to be driven
    postfix_res_t postfix_exp [$];  // predicted results, oldest first

    // Shadow of the converter's operator stack
    logic [7:0] op_stk [DEPTH];
    int         stk_cnt = 0;
    logic       stk_ovf = 1'b0;

    int n_total     = 0;
    int n_taken     = 0;
    int n_results   = 0;
    int n_bad       = 0;
    int n_exprs     = 0;
    int n_ovf_exprs = 0;
    int max_depth   = 0;

    infix_to_postfix_converter #(
        .STACK_DEPTH(DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_char   (i_in_char),
        .i_is_end    (i_is_end),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_char  (o_out_char),
        .o_run_last  (o_run_last),
        .o_expr_done (o_expr_done),
        .o_overflowed(o_overflowed)
    );

    always #(HALF_CYCLE) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shunting-yard predictor
    // ------------------------------------------------------------------

    function automatic logic [1:0] op_rank(input logic [7:0] ch);
        logic [1:0] r;
        case (ch)
            C_PLUS, C_MINUS: r = 2'd1;
            C_STAR, C_SLASH: r = 2'd2;
            C_CARET:         r = 2'd3;
            default:         r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_name_char(input logic [7:0] ch);
        return (ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "Z") ||
               (ch >= "a" && ch <= "z");
    endfunction

    // The flag travels with each result as it stands at the moment of the emit.
    task automatic emit_res(input logic [7:0] ch, input logic done);
        postfix_res_t r;
        r.ch   = ch;
        r.last = 1'b0;
        r.done = done;
        r.ovf  = stk_ovf;
        postfix_exp.push_back(r);
    endtask

    task automatic pop_res();
        stk_cnt--;
        emit_res(op_stk[stk_cnt], 1'b0);
    endtask

    // Drop a push onto a full stack and flag it for the rest of the expression.
    task automatic push_op(input logic [7:0] ch);
        if (stk_cnt >= DEPTH) begin
            stk_ovf = 1'b1;
        end else begin
            op_stk[stk_cnt] = ch;
            stk_cnt++;
            if (stk_cnt > max_depth) max_depth = stk_cnt;
        end
    endtask

    task automatic shunt_item(input logic [7:0] ch, input logic fin);
        int           n0;
        logic [1:0]   rank;
        postfix_res_t tail;
        n0 = postfix_exp.size();
        if (fin) begin
            // Drain everything, '(' included, then close with the end marker.
            while (stk_cnt > 0) pop_res();
            emit_res(C_NUL, 1'b1);
            n_exprs++;
            if (stk_ovf) n_ovf_exprs++;
            stk_cnt = 0;
            stk_ovf = 1'b0;
        end else if (is_name_char(ch)) begin
            emit_res(ch, 1'b0);
        end else if (ch == C_LPAREN) begin
            push_op(ch);
        end else if (ch == C_RPAREN) begin
            // Unmatched ')' just empties the stack; a matched one discards its '('.
            while (stk_cnt > 0 && op_stk[stk_cnt - 1] != C_LPAREN) pop_res();
            if (stk_cnt > 0) stk_cnt--;
        end else begin
            // Rank-zero characters (space, NUL, bytes above 127, ...) pop it all.
            rank = op_rank(ch);
            while (stk_cnt > 0 && op_rank(op_stk[stk_cnt - 1]) >= rank) pop_res();
            push_op(ch);
        end
        if (postfix_exp.size() > n0) begin
            tail = postfix_exp.pop_back();
            tail.last = 1'b1;
            postfix_exp.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    task automatic add_item(input logic [7:0] ch, input logic fin);
        char_item_t it;
        it.ch  = ch;
        it.fin = fin;
        char_feed.push_back(it);
    endtask

    task automatic add_operand();
        case ($urandom_range(0, 2))
            0:       add_item(CH_DIG0 + 8'($urandom_range(0, 9)), 1'b0);
            1:       add_item(CH_UPA + 8'($urandom_range(0, 25)), 1'b0);
            default: add_item(CH_LOWA + 8'($urandom_range(0, 25)), 1'b0);
        endcase
    endtask

    task automatic add_end();
        add_item(8'($urandom_range(0, 255)), 1'b1);  // char is a don't-care here
    endtask

    // Well-formed expression, nested a few levels deep.
    task automatic add_expr(input int level);
        int terms;
        terms = $urandom_range(1, 4);
        for (int t = 0; t < terms; t++) begin
            if (t > 0) add_item(OPS[$urandom_range(0, 4)], 1'b0);
            if (level < 4 && $urandom_range(0, 3) == 0) begin
                add_item(C_LPAREN, 1'b0);
                add_expr(level + 1);
                add_item(C_RPAREN, 1'b0);
            end else begin
                add_operand();
            end
        end
    endtask

    // Each level stacks a '(' and an operator, so 17 or more levels overflow.
    task automatic add_deep(input int levels);
        for (int k = 0; k < levels; k++) begin
            add_item(C_LPAREN, 1'b0);
            add_operand();
            add_item(OPS[$urandom_range(0, 4)], 1'b0);
        end
        add_operand();
        repeat ($urandom_range(0, levels)) add_item(C_RPAREN, 1'b0);
        add_end();
    endtask

    // Broken sequences: stray brackets, operators in a row, arbitrary bytes.
    task automatic add_noise();
        repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 5))
                0:       add_operand();
                1:       add_item(OPS[$urandom_range(0, 4)], 1'b0);
                2:       add_item(C_LPAREN, 1'b0);
                3:       add_item(C_RPAREN, 1'b0);
                default: add_item(8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
        add_end();
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of items separated by random gaps
    // ------------------------------------------------------------------

    int         burst_left = 1;
    int         gap_left   = 0;
    char_item_t next_item;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                shunt_item(i_in_char, i_is_end);
                n_taken++;
            end
            // Hold the payload while stalled; otherwise advance.
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (char_feed.size() > 0) begin
                    next_item = char_feed.pop_front();
                    i_valid   <= 1'b1;
                    i_in_char <= next_item.ch;
                    i_is_end  <= next_item.fin;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else if ($urandom_range(0, 4) == 0) begin
                        // long stretch with no gaps at all
                        burst_left = $urandom_range(30, 60);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(1, 16);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted result and drive the output stall
    // ------------------------------------------------------------------

    int   stall_mode = 0;
    int   mode_left  = 0;
    int   run_left   = 0;
    logic run_stall  = 1'b0;
    logic stall_nxt;

    task automatic flag_bad(input string why, input postfix_res_t want,
                            input postfix_res_t got);
        n_bad++;
        if (n_bad <= 10)
            $display("mismatch %0d, %s: expected char=%02h last=%b done=%b ovf=%b, ",
                     n_bad, why, want.ch, want.last, want.done, want.ovf,
                     "got char=%02h last=%b done=%b ovf=%b",
                     got.ch, got.last, got.done, got.ovf);
    endtask

    always @(posedge i_clk) begin
        postfix_res_t got;
        postfix_res_t want;
        got.ch   = o_out_char;
        got.last = o_run_last;
        got.done = o_expr_done;
        got.ovf  = o_overflowed;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (postfix_exp.size() == 0) begin
                flag_bad("no result expected", '0, got);
            end else begin
                want = postfix_exp.pop_front();
                if (got.ch !== want.ch || got.last !== want.last ||
                    got.done !== want.done || got.ovf !== want.ovf)
                    flag_bad("field differs", want, got);
            end
        end

        // Switch the stall pattern every so often: none, light, heavy, long runs.
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 250);
        end
        mode_left--;
        case (stall_mode)
            0: stall_nxt = 1'b0;
            1: stall_nxt = ($urandom_range(0, 3) == 0);
            2: stall_nxt = ($urandom_range(0, 3) != 0);
            default: begin
                if (run_left == 0) begin
                    run_stall = ~run_stall;
                    run_left  = run_stall ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                run_left--;
                stall_nxt = run_stall;
            end
        endcase
        i_stall <= stall_nxt;
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if neither side moves for too long
    // ------------------------------------------------------------------

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("watchdog: no handshake for %0d cycles, %0d results still due",
                             IDLE_LIMIT, postfix_exp.size());
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        int n_directed;

        // Every operator, both brackets, left-associative '^', digit and
        // letter extremes: (0+9*A^Z^z/a)-9
        add_item(C_LPAREN, 1'b0);
        add_item("0", 1'b0);
        add_item(C_PLUS, 1'b0);
        add_item("9", 1'b0);
        add_item(C_STAR, 1'b0);
        add_item("A", 1'b0);
        add_item(C_CARET, 1'b0);
        add_item("Z", 1'b0);
        add_item(C_CARET, 1'b0);
        add_item("z", 1'b0);
        add_item(C_SLASH, 1'b0);
        add_item("a", 1'b0);
        add_item(C_RPAREN, 1'b0);
        add_item(C_MINUS, 1'b0);
        add_item("9", 1'b0);
        add_item(8'h00, 1'b1);
        // Unmatched ')' drains the stack; a second one finds it empty.
        add_item(C_PLUS, 1'b0);
        add_item(C_RPAREN, 1'b0);
        add_item(C_RPAREN, 1'b0);
        add_item(8'h00, 1'b1);
        // Rank-zero characters pop everything, '(' included; a '(' left
        // on the stack goes out with the end item.
        add_item(C_LPAREN, 1'b0);
        add_item(C_STAR, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'h80, 1'b0);
        add_item(" ", 1'b0);
        add_item(C_LPAREN, 1'b0);
        add_item(8'hFF, 1'b1);
        n_directed = char_feed.size();

        // Random part: start with a guaranteed overflow, then mostly
        // well-formed expressions with some deep nesting and some garbage.
        add_deep(20);
        while (char_feed.size() < n_directed + N_RANDOM) begin
            case ($urandom_range(0, 9))
                0:       add_deep($urandom_range(4, 24));
                1, 2:    add_noise();
                default: begin
                    add_expr(0);
                    add_end();
                end
            endcase
        end
        n_total = char_feed.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every item to go in and every result to come out,
        // then give the converter time to show any stray extra result.
        wait (n_taken == n_total);
        while (postfix_exp.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("ran %0d input items over %0d expressions, checked %0d postfix results",
                 n_taken, n_exprs, n_results);
        $display("deepest stack %0d entries, %0d expressions overflowed, %0d mismatches",
                 max_depth, n_ovf_exprs, n_bad);
        if (n_bad == 0 && postfix_exp.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
